>>> rtl/core/max_heap_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max-heap priority queue
// Shorthand for clocked implication checks that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Command and status codes, result widths and the sequencer state type.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int VALUE_IN_BITS  = 32;
   localparam int POPPED_BITS    = 32;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_UP_RD    = 8'b0000_0010,
      ST_UP_CMP   = 8'b0000_0100,
      ST_POP_LAST = 8'b0000_1000,
      ST_DN_LOAD  = 8'b0001_0000,
      ST_DN_RD_L  = 8'b0010_0000,
      ST_DN_RD_R  = 8'b0100_0000,
      ST_DN_CMP   = 8'b1000_0000
   } state_type;

endpackage

>>> rtl/core/mhpq_store.sv
// ----------------------------------------------------------------------------
// Heap entry store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module mhpq_store #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/max_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue unit
// Binary max-heap of signed values with insert and pop-maximum commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command item is taken at a rising edge where start is high and busy is
//   low. req_cmd selects insert (req_value is added) or pop (the maximum is
//   removed). Every command yields exactly one result item: rsp_strobe is high
//   for one cycle with the popped value (zero unless a pop succeeded), a
//   status code and the entry count after the command.
//   A full insert or an empty pop changes nothing and answers in the cycle
//   right after acceptance, with busy staying low.
//   An insert reads each parent in turn and moves it down while it is smaller
//   than the new value, then writes the new value into the hole.
//   A pop fetches the root and the last entry, then for each level it
//   descends reads the left child, reads the right child and compares.
//   The rate is set by the single read port of the entry store and the one
//   shared comparator: each heap level costs one read per compared entry plus
//   the decision step, and busy holds further commands off meanwhile.
//   Reset empties the heap; the store contents need no clearing because only
//   entries below the count are ever used. The result receiver cannot stall:
//   a result is delivered in its strobe cycle and held until the next one.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_unit_macros.svh"

module max_heap_priority_queue_unit #(
   parameter int CAPACITY   = 128,
   parameter int VALUE_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_cmd,
   input  logic signed [mhpq_pkg::VALUE_IN_BITS-1:0] req_value,
   output logic                                     rsp_strobe,
   output logic signed [mhpq_pkg::POPPED_BITS-1:0]   rsp_popped_value,
   output logic [mhpq_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic [mhpq_pkg::COUNT_OUT_BITS-1:0]       rsp_entry_count_out
);

   // Positions are 1-based and run up to CAPACITY; store indexes are 0-based.
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   mhpq_pkg::state_type state_ff, state_in;

   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [CW-1:0]               best_pos_ff, best_pos_in;
   logic                        best_dn_ff, best_dn_in;
   logic                        has_r_ff, has_r_in;
   logic signed [VALUE_BITS-1:0] mov_ff, mov_in;
   logic signed [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic signed [VALUE_BITS-1:0] top_ff, top_in;

   logic                                     rsp_strobe_ff, rsp_strobe_in;
   logic signed [mhpq_pkg::POPPED_BITS-1:0]   rsp_popped_ff, rsp_popped_in;
   logic [mhpq_pkg::STATUS_BITS-1:0]          rsp_status_ff, rsp_status_in;
   logic [mhpq_pkg::COUNT_OUT_BITS-1:0]       rsp_count_ff, rsp_count_in;

   // Store port signals.
   logic                  wr_en;
   logic [IW-1:0]         wr_idx;
   logic [VALUE_BITS-1:0] wr_data;
   logic [IW-1:0]         rd_idx;
   logic [VALUE_BITS-1:0] rd_data;

   // The one shared comparator: cmp_lt is true when cmp_lo < cmp_hi, signed.
   logic signed [VALUE_BITS-1:0] cmp_lo, cmp_hi;
   logic                         cmp_lt;

   logic [CW:0] child_l, child_r, count_ext;
   logic [CW-1:0] parent_pos;
   logic [IW-1:0] pos_idx;
   logic          accept;
   logic          take_r;

   assign busy      = (state_ff != mhpq_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign child_l   = {pos_ff, 1'b0};
   assign child_r   = {pos_ff, 1'b1};
   assign count_ext = {1'b0, count_ff};
   assign parent_pos = pos_ff >> 1;
   assign pos_idx   = IW'(pos_ff - CW'(1));
   assign cmp_lt    = (cmp_lo < cmp_hi);
   assign take_r    = has_r_ff && cmp_lt;

   mhpq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      best_pos_in   = best_pos_ff;
      best_dn_in    = best_dn_ff;
      has_r_in      = has_r_ff;
      mov_in        = mov_ff;
      best_val_in   = best_val_ff;
      top_in        = top_ff;
      rsp_strobe_in = 1'b0;
      rsp_popped_in = rsp_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_idx        = pos_idx;
      wr_data       = mov_ff;
      // The idle read of the root primes a pop.
      rd_idx        = '0;
      cmp_lo        = mov_ff;
      cmp_hi        = $signed(rd_data);

      unique case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == mhpq_pkg::CMD_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_popped_in = '0;
                     rsp_status_in = mhpq_pkg::STATUS_FULL;
                     rsp_count_in  = mhpq_pkg::COUNT_OUT_BITS'(count_ff);
                  end else begin
                     count_in = count_ff + CW'(1);
                     pos_in   = count_ff + CW'(1);
                     mov_in   = VALUE_BITS'(req_value);
                     state_in = mhpq_pkg::ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_popped_in = '0;
                     rsp_status_in = mhpq_pkg::STATUS_EMPTY;
                     rsp_count_in  = mhpq_pkg::COUNT_OUT_BITS'(count_ff);
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = mhpq_pkg::ST_POP_LAST;
                  end
               end
            end
         end

         mhpq_pkg::ST_UP_RD: begin
            if (pos_ff == CW'(1)) begin
               wr_en         = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_popped_in = '0;
               rsp_status_in = mhpq_pkg::STATUS_OK;
               rsp_count_in  = mhpq_pkg::COUNT_OUT_BITS'(count_ff);
               state_in      = mhpq_pkg::ST_IDLE;
            end else begin
               rd_idx   = IW'(parent_pos - CW'(1));
               state_in = mhpq_pkg::ST_UP_CMP;
            end
         end

         mhpq_pkg::ST_UP_CMP: begin
            cmp_lo = $signed(rd_data);
            cmp_hi = mov_ff;
            wr_en  = 1'b1;
            if (cmp_lt) begin
               // Parent moves down into the hole; the hole climbs.
               wr_data  = rd_data;
               pos_in   = parent_pos;
               state_in = mhpq_pkg::ST_UP_RD;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_popped_in = '0;
               rsp_status_in = mhpq_pkg::STATUS_OK;
               rsp_count_in  = mhpq_pkg::COUNT_OUT_BITS'(count_ff);
               state_in      = mhpq_pkg::ST_IDLE;
            end
         end

         mhpq_pkg::ST_POP_LAST: begin
            top_in   = $signed(rd_data);
            rd_idx   = IW'(count_ff);
            state_in = mhpq_pkg::ST_DN_LOAD;
         end

         mhpq_pkg::ST_DN_LOAD: begin
            mov_in   = $signed(rd_data);
            pos_in   = CW'(1);
            state_in = mhpq_pkg::ST_DN_RD_L;
         end

         mhpq_pkg::ST_DN_RD_L: begin
            if (child_l > count_ext) begin
               wr_en         = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_popped_in = mhpq_pkg::POPPED_BITS'(top_ff);
               rsp_status_in = mhpq_pkg::STATUS_OK;
               rsp_count_in  = mhpq_pkg::COUNT_OUT_BITS'(count_ff);
               state_in      = mhpq_pkg::ST_IDLE;
            end else begin
               rd_idx   = IW'(child_l - (CW+1)'(1));
               state_in = mhpq_pkg::ST_DN_RD_R;
            end
         end

         mhpq_pkg::ST_DN_RD_R: begin
            // Left child has arrived; it wins only if strictly larger.
            if (cmp_lt) begin
               best_val_in = $signed(rd_data);
               best_pos_in = CW'(child_l);
               best_dn_in  = 1'b1;
            end else begin
               best_val_in = mov_ff;
               best_dn_in  = 1'b0;
            end
            has_r_in = (child_r <= count_ext);
            rd_idx   = IW'(child_l);
            state_in = mhpq_pkg::ST_DN_CMP;
         end

         mhpq_pkg::ST_DN_CMP: begin
            cmp_lo = best_val_ff;
            wr_en  = 1'b1;
            if (best_dn_ff || take_r) begin
               // Larger child moves up into the hole; the hole descends.
               wr_data  = take_r ? rd_data : best_val_ff;
               pos_in   = take_r ? CW'(child_r) : best_pos_ff;
               state_in = mhpq_pkg::ST_DN_RD_L;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_popped_in = mhpq_pkg::POPPED_BITS'(top_ff);
               rsp_status_in = mhpq_pkg::STATUS_OK;
               rsp_count_in  = mhpq_pkg::COUNT_OUT_BITS'(count_ff);
               state_in      = mhpq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mhpq_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      best_pos_ff   <= best_pos_in;
      best_dn_ff    <= best_dn_in;
      has_r_ff      <= has_r_in;
      mov_ff        <= mov_in;
      best_val_ff   <= best_val_in;
      top_ff        <= top_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_popped_value    = rsp_popped_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_count_out = rsp_count_ff;

   `MHPQ_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "entry count beyond capacity")
   `MHPQ_ASSERT_NEXT(a_count_held_while_busy, clock, reset, busy, count_ff == $past(count_ff), "entry count changed during a sift")
   `MHPQ_ASSERT_SAME(a_write_only_when_busy, clock, reset, wr_en, busy, "store written while idle")
   `MHPQ_ASSERT_NEXT(a_empty_pop_flagged, clock, reset, accept && req_cmd == mhpq_pkg::CMD_POP && count_ff == '0, rsp_strobe && rsp_status == mhpq_pkg::STATUS_EMPTY, "empty pop not flagged")

endmodule
